FILE: sv/kct_pkg.sv
// kct_pkg: shared types and constants for the keyed count table.
// Holds the action codes, the request and response words, the FSM states
// and the structs passed between the sequencer and the update logic.
`default_nettype none

package kct_pkg;

	localparam int KEY_W = 32;
	localparam int CNT_W = 31;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_CLEAR  = 2'd3
	} act_t;

	typedef struct packed {
		act_t              action;
		logic [KEY_W-1:0]  item_key;
		logic [CNT_W-1:0]  amount;
	} req_word_t;

	typedef struct packed {
		logic [CNT_W-1:0]  result_value;
		logic              present;
		logic              changed;
		logic              full_error;
		logic              saturated;
	} rsp_word_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_EXEC = 2'd2
	} st_t;

	// lookup outcome handed to the update logic
	typedef struct packed {
		act_t              action;
		logic [KEY_W-1:0]  item_key;
		logic [CNT_W-1:0]  amount;
		logic              found;
		logic [CNT_W-1:0]  cnt;
		logic              free_fnd;
	} exec_ctx_t;

	// table update and response decided by the update logic
	typedef struct packed {
		logic              wr_en;
		logic              use_free;
		logic              set_valid;
		logic              clr_valid;
		logic              clr_all;
		logic [CNT_W-1:0]  wr_count;
		rsp_word_t         rsp;
	} exec_dec_t;

endpackage

`default_nettype wire

FILE: sv/kct_ram.sv
// kct_ram: generic single-write, single-read synchronous RAM.
// Read data is registered. No dependencies.
`default_nettype none

module kct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/kct_exec.sv
// kct_exec: update decision for one word once the lookup has finished.
// Works out the new count, the table write and the response word.
// Depends on kct_pkg.
`default_nettype none

module kct_exec (
	input  wire kct_pkg::exec_ctx_t ctx,
	output kct_pkg::exec_dec_t      dec
);
	import kct_pkg::*;

	logic             key_ok;
	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] add_cnt;
	logic [CNT_W-1:0] take;
	logic [CNT_W-1:0] rem_cnt;

	always_comb begin
		key_ok  = (ctx.item_key != '0) && (ctx.amount != '0);
		sum     = {1'b0, ctx.cnt} + {1'b0, ctx.amount};
		add_cnt = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
		take    = (ctx.amount < ctx.cnt) ? ctx.amount : ctx.cnt;
		rem_cnt = ctx.cnt - take;
	end

	always_comb begin
		dec = '0;
		unique case (ctx.action)
			ACT_ADD: begin
				if (key_ok && ctx.found) begin
					dec.wr_en             = 1'b1;
					dec.wr_count          = add_cnt;
					dec.rsp.result_value  = add_cnt;
					dec.rsp.present       = 1'b1;
					dec.rsp.changed       = (add_cnt != ctx.cnt);
					dec.rsp.saturated     = sum[CNT_W];
				end else if (key_ok && ctx.free_fnd) begin
					dec.wr_en             = 1'b1;
					dec.use_free          = 1'b1;
					dec.set_valid         = 1'b1;
					dec.wr_count          = ctx.amount;
					dec.rsp.result_value  = ctx.amount;
					dec.rsp.present       = 1'b1;
					dec.rsp.changed       = 1'b1;
				end else if (key_ok) begin
					dec.rsp.full_error    = 1'b1;
				end else begin
					dec.rsp.result_value  = ctx.found ? ctx.cnt : '0;
					dec.rsp.present       = ctx.found;
				end
			end
			ACT_REMOVE: begin
				if (key_ok && ctx.found) begin
					dec.wr_en             = 1'b1;
					dec.wr_count          = rem_cnt;
					dec.clr_valid         = (rem_cnt == '0);
					dec.rsp.result_value  = take;
					dec.rsp.present       = (rem_cnt != '0);
					dec.rsp.changed       = 1'b1;
				end else begin
					dec.rsp.present       = ctx.found;
				end
			end
			ACT_QUERY: begin
				dec.rsp.result_value = ctx.found ? ctx.cnt : '0;
				dec.rsp.present      = ctx.found;
			end
			ACT_CLEAR: begin
				dec.clr_all     = 1'b1;
				dec.rsp.changed = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/keyed_count_table.sv
// keyed_count_table: associative table of keys with saturating counts.
// Add, remove and query scan the entry RAM one slot a cycle and stop at a
// matching slot or after the last slot; clear skips the scan.
// A new word is taken only once the last one has committed its update, as
// req_stall holds off requests; a waiting result holds only the final update.
// Reset clears the slot valid flags at once. Needs kct_pkg, kct_ram, kct_exec.
`default_nettype none

module keyed_count_table #(
	parameter int CAPACITY = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire kct_pkg::req_word_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output kct_pkg::rsp_word_t      rsp
);
	import kct_pkg::*;

	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNTR_W = $clog2(CAPACITY + 1);
	localparam int ENT_W  = KEY_W + CNT_W;

	st_t               state_q, state_nx;
	logic [CAPACITY-1:0] valid_q;

	act_t              act_q;
	logic [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]  amt_q;
	logic              found_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  slot_q;
	logic              free_fnd_q;
	logic [IDX_W-1:0]  free_idx_q;

	logic [CNTR_W-1:0] iss_q;
	logic              chk_vld_s1;
	logic [IDX_W-1:0]  chk_idx_s1;

	logic              accept;
	logic              issue;
	logic              hit;
	logic              last;
	logic              scan_done;
	logic              commit;

	logic [ENT_W-1:0]  rd_data;
	logic [KEY_W-1:0]  rd_key;
	logic [CNT_W-1:0]  rd_cnt;
	logic [IDX_W-1:0]  wr_addr;

	exec_ctx_t         ctx;
	exec_dec_t         dec;

	rsp_word_t         rsp_q;
	logic              rsp_valid_q;

	kct_ram #(
		.WIDTH (ENT_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (commit && dec.wr_en),
		.wr_addr (wr_addr),
		.wr_data ({key_q, dec.wr_count}),
		.rd_en   (issue),
		.rd_addr (iss_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	assign rd_key = rd_data[ENT_W-1:CNT_W];
	assign rd_cnt = rd_data[CNT_W-1:0];

	always_comb begin
		hit       = chk_vld_s1 && valid_q[chk_idx_s1] && (rd_key == key_q) && (key_q != '0);
		last      = (chk_idx_s1 == IDX_W'(CAPACITY - 1));
		scan_done = chk_vld_s1 && (hit || last);
		wr_addr   = dec.use_free ? free_idx_q : slot_q;
	end

	always_comb begin
		ctx.action   = act_q;
		ctx.item_key = key_q;
		ctx.amount   = amt_q;
		ctx.found    = found_q;
		ctx.cnt      = cnt_q;
		ctx.free_fnd = free_fnd_q;
	end

	kct_exec u_exec (
		.ctx (ctx),
		.dec (dec)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nx = (req.action == ACT_CLEAR) ? ST_EXEC : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req_stall = (state_q != ST_IDLE);
		accept    = (state_q == ST_IDLE) && req_valid;
		issue     = (state_q == ST_SCAN) && (iss_q < CNTR_W'(CAPACITY)) && !scan_done;
		commit    = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			chk_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_nx;
			chk_vld_s1 <= issue;
			if (commit) begin
				if (dec.clr_all) begin
					valid_q <= '0;
				end else if (dec.set_valid) begin
					valid_q[wr_addr] <= 1'b1;
				end else if (dec.clr_valid) begin
					valid_q[wr_addr] <= 1'b0;
				end
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= iss_q[IDX_W-1:0];
		if (accept) begin
			act_q      <= req.action;
			key_q      <= req.item_key;
			amt_q      <= req.amount;
			found_q    <= 1'b0;
			free_fnd_q <= 1'b0;
			iss_q      <= '0;
		end else begin
			if (issue) begin
				iss_q <= iss_q + CNTR_W'(1);
			end
			if (chk_vld_s1 && !valid_q[chk_idx_s1] && !free_fnd_q) begin
				free_fnd_q <= 1'b1;
				free_idx_q <= chk_idx_s1;
			end
			if (scan_done) begin
				found_q <= hit;
				cnt_q   <= rd_cnt;
				slot_q  <= chk_idx_s1;
			end
		end
		if (commit) begin
			rsp_q <= dec.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (iss_q <= CNTR_W'(CAPACITY)))
		else $error("scan counter ran past the table");

	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && found_q) |-> valid_q[slot_q])
		else $error("lookup hit on a free slot");

	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && dec.rsp.full_error) |-> (&valid_q))
		else $error("full reported with a free slot");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && dec.clr_all) |=> (valid_q == '0))
		else $error("clear left slots in use");
`endif

endmodule

`default_nettype wire
